// File: sv/wbe_pkg.sv
// Shared types and constants of the windowed bias estimator.
package wbe_pkg;

   localparam int IN_SAMPLE_W  = 16;
   localparam int BIAS_W       = 24;
   localparam int FILL_W       = 9;
   localparam int REQ_DATA_W   = 3 * IN_SAMPLE_W;
   localparam int RSP_FIELDS_W = 3 * BIAS_W + FILL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int FRAC_W       = 8;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef struct packed {
      logic fetch;     // latch sample, read slot at write pointer
      logic clear;     // empty the window
      logic update;    // evict, add, write slot, advance pointer
      logic div_load;  // load divider lanes from the sums
      logic div_step;  // one quotient bit on every lane
      logic emit;      // move quotients into the result register
   } wbe_cmd_type;

   typedef struct packed {
      logic div_last;  // current step is the final one
      logic out_free;  // result register can take a new item
   } wbe_status_type;

endpackage

// File: sv/windowed_bias_estimator.sv
// Top level of the windowed bias estimator for a three-axis sensor.
//
//  channel | direction | fields
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | tdata: sample_x, sample_y, sample_z; tuser: action;
//          |           | tlast: batch_end
//  rsp_    | out       | tdata: bias_x, bias_y, bias_z, fill_count
//
// A push is fetched and then updated; a push that ends a batch then loads the
// bit-serial divider, which produces one quotient bit per axis per cycle, and
// emits the result. A clear is applied as it is accepted.
// Reset empties the window at once; the ring itself is not cleared.
// A stalled result sits in its own register; items are taken meanwhile, but the
// next result waits for it in the emit state and holds off further requests.
module windowed_bias_estimator
   import wbe_pkg::*;
#(
   parameter int WINDOW      = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_x, sample_y, sample_z
   input  logic                  req_tuser,   // action
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // bias_x, bias_y, bias_z, fill_count, zeros
);

   wbe_cmd_type    cmd;
   wbe_status_type status;

   wbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   wbe_datapath #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: sv/wbe_div_lane.sv
// One axis of the mean divider: restoring division of |sum| * 256 by the fill count.
module wbe_div_lane
   import wbe_pkg::*;
#(
   parameter int SUM_W = 24,
   parameter int CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic                     step,
   input  logic signed [SUM_W-1:0]  sum,
   input  logic [CNT_W-1:0]         divisor,
   output logic [BIAS_W-1:0]        bias
);

   localparam int Q_W   = SUM_W + FRAC_W;
   localparam int CMP_W = (Q_W > BIAS_W + 1) ? Q_W : BIAS_W + 1;
   localparam logic [CMP_W-1:0] POS_LIM = CMP_W'(2 ** (BIAS_W - 1) - 1);
   localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(2 ** (BIAS_W - 1));
   localparam logic [BIAS_W-1:0] BIAS_MAX = BIAS_W'(2 ** (BIAS_W - 1) - 1);
   localparam logic [BIAS_W-1:0] BIAS_MIN = BIAS_W'(2 ** (BIAS_W - 1));

   logic             neg_ff, neg_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] mag;
   logic [CNT_W:0]   shifted;
   logic [CNT_W:0]   diff;
   logic [CMP_W-1:0] mag_wide;

   assign mag     = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
   assign shifted = {rem_ff, quo_ff[Q_W-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (load) begin
         neg_in = sum[SUM_W-1];
         quo_in = {mag, {FRAC_W{1'b0}}};
         rem_in = '0;
      end else if (step) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_W-1:0];
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // Apply the sign to the magnitude quotient and clamp to the output range
   assign mag_wide = CMP_W'(quo_ff);

   always_comb begin
      if (neg_ff) begin
         if (mag_wide > NEG_LIM) begin
            bias = BIAS_MIN;
         end else begin
            bias = BIAS_W'(~mag_wide + CMP_W'(1));
         end
      end else begin
         if (mag_wide > POS_LIM) begin
            bias = BIAS_MAX;
         end else begin
            bias = BIAS_W'(mag_wide);
         end
      end
   end

endmodule

// File: sv/wbe_datapath.sv
// Datapath: sample ring, running sums, fill count, divider lanes and result register.
module wbe_datapath
   import wbe_pkg::*;
#(
   parameter int WINDOW      = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  wbe_cmd_type           cmd,
   output wbe_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int Q_W    = SUM_W + FRAC_W;
   localparam int STEP_W = $clog2(Q_W);
   localparam int ENT_W  = 3 * SAMPLE_BITS;

   logic [ENT_W-1:0] ring_mem [WINDOW];
   logic [ENT_W-1:0] rd_ff;

   logic signed [SAMPLE_BITS-1:0] smp_x_ff, smp_y_ff, smp_z_ff;
   logic signed [SAMPLE_BITS-1:0] old_x, old_y, old_z;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [SUM_W-1:0] sum_z_ff, sum_z_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              full;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [BIAS_W-1:0] bias_x, bias_y, bias_z;

   assign full = (cnt_ff == CNT_W'(WINDOW));

   // Oldest sample leaves the sums only once the ring is full
   always_comb begin
      if (full) begin
         old_x = $signed(rd_ff[SAMPLE_BITS-1:0]);
         old_y = $signed(rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);
         old_z = $signed(rd_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
      end else begin
         old_x = '0;
         old_y = '0;
         old_z = '0;
      end
   end

   always_comb begin
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      if (cmd.clear) begin
         ptr_in   = '0;
         cnt_in   = '0;
         sum_x_in = '0;
         sum_y_in = '0;
         sum_z_in = '0;
      end else if (cmd.update) begin
         ptr_in   = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
         cnt_in   = full ? cnt_ff : cnt_ff + 1'b1;
         sum_x_in = sum_x_ff + SUM_W'(smp_x_ff) - SUM_W'(old_x);
         sum_y_in = sum_y_ff + SUM_W'(smp_y_ff) - SUM_W'(old_y);
         sum_z_in = sum_z_ff + SUM_W'(smp_z_ff) - SUM_W'(old_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         cnt_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
      end
   end

   // Bits above SAMPLE_BITS drop; a wider sample takes the 16 bits unsigned
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         smp_x_ff <= SAMPLE_BITS'(req_tdata[IN_SAMPLE_W-1:0]);
         smp_y_ff <= SAMPLE_BITS'(req_tdata[2*IN_SAMPLE_W-1:IN_SAMPLE_W]);
         smp_z_ff <= SAMPLE_BITS'(req_tdata[3*IN_SAMPLE_W-1:2*IN_SAMPLE_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_ff <= ring_mem[ptr_ff];
      end
      if (cmd.update) begin
         ring_mem[ptr_ff] <= {smp_z_ff, smp_y_ff, smp_x_ff};
      end
   end

   // Step counter shared by the three lanes
   always_comb begin
      step_in = step_ff;
      if (cmd.div_load) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign status.div_last = (step_ff == STEP_W'(Q_W - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   wbe_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_x (
      .clock   (clock),
      .load    (cmd.div_load),
      .step    (cmd.div_step),
      .sum     (sum_x_ff),
      .divisor (cnt_ff),
      .bias    (bias_x)
   );

   wbe_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_y (
      .clock   (clock),
      .load    (cmd.div_load),
      .step    (cmd.div_step),
      .sum     (sum_y_ff),
      .divisor (cnt_ff),
      .bias    (bias_y)
   );

   wbe_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_z (
      .clock   (clock),
      .load    (cmd.div_load),
      .step    (cmd.div_step),
      .sum     (sum_z_ff),
      .divisor (cnt_ff),
      .bias    (bias_z)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, FILL_W'(cnt_ff), bias_z, bias_y, bias_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (cnt_ff == '0) && (ptr_ff == '0) && (sum_x_ff == '0))
      else $error("clear left the window occupied");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && full) |=> full)
      else $error("full window lost a sample");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid && (rsp_tdata[3*BIAS_W +: FILL_W] == FILL_W'($past(cnt_ff))))
      else $error("result not presented after emit");

endmodule

// File: sv/wbe_ctrl.sv
// Controller: sequences sample update, division and result hand-off.
module wbe_ctrl
   import wbe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  logic           req_tlast,
   input  wbe_status_type status,
   output wbe_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.fetch = 1'b1;
                  last_in   = req_tlast;
                  state_in  = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   a_update_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> cmd.update)
      else $error("sample read not followed by update");

   a_div_after_batch: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |=> cmd.div_load)
      else $error("batch end did not start division");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwritten while waiting");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the windowed bias estimator: directed and random streams.
`timescale 1ns / 100ps

module tb;
   import wbe_pkg::*;

   localparam int RING_DEPTH = 256;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_ITEMS = 290;

   typedef struct packed {
      logic signed [BIAS_W-1:0] bias_x;
      logic signed [BIAS_W-1:0] bias_y;
      logic signed [BIAS_W-1:0] bias_z;
      logic [FILL_W-1:0]        fill;
   } bias_mean_type;

   typedef enum int {STYLE_FULL, STYLE_RAIL, STYLE_NEAR} sample_style_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // sample_x, sample_y, sample_z
   logic                  req_tuser = ACT_PUSH;   // action
   logic                  req_tlast = 1'b0;   // batch_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // bias_x, bias_y, bias_z, fill_count, zeros

   // predictor state
   logic signed [IN_SAMPLE_W-1:0] ring_x [RING_DEPTH];
   logic signed [IN_SAMPLE_W-1:0] ring_y [RING_DEPTH];
   logic signed [IN_SAMPLE_W-1:0] ring_z [RING_DEPTH];
   int unsigned ring_head = 0;
   int unsigned held = 0;
   longint      total_x = 0;
   longint      total_y = 0;
   longint      total_z = 0;
   bias_mean_type pending_means[$];

   // control and tallies
   bit          steady = 1'b0;
   int unsigned hold_ticket = 0;
   int unsigned fault_count = 0;
   int unsigned items_sent = 0;
   int unsigned clears_sent = 0;
   int unsigned means_checked = 0;
   int unsigned evictions = 0;

   windowed_bias_estimator #(
      .WINDOW      (RING_DEPTH),
      .SAMPLE_BITS (IN_SAMPLE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [BIAS_W-1:0] axis_mean(input longint total, input longint n);
      longint q;
      q = (total * 256) / n;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[BIAS_W-1:0];
   endfunction

   function automatic void predict_item(input logic act, input logic signed [IN_SAMPLE_W-1:0] sx,
                                        input logic signed [IN_SAMPLE_W-1:0] sy,
                                        input logic signed [IN_SAMPLE_W-1:0] sz,
                                        input logic last);
      bias_mean_type m;
      if (act == ACT_CLEAR) begin
         ring_head = 0;
         held = 0;
         total_x = 0;
         total_y = 0;
         total_z = 0;
         return;
      end
      // oldest sample leaves the sums before its slot is reused
      if (held >= RING_DEPTH) begin
         total_x -= ring_x[ring_head];
         total_y -= ring_y[ring_head];
         total_z -= ring_z[ring_head];
         evictions++;
      end else begin
         held++;
      end
      ring_x[ring_head] = sx;
      ring_y[ring_head] = sy;
      ring_z[ring_head] = sz;
      total_x += sx;
      total_y += sy;
      total_z += sz;
      ring_head = (ring_head + 1) % RING_DEPTH;
      if (!last) return;
      m.bias_x = axis_mean(total_x, longint'(held));
      m.bias_y = axis_mean(total_y, longint'(held));
      m.bias_z = axis_mean(total_z, longint'(held));
      m.fill   = held[FILL_W-1:0];
      pending_means.push_back(m);
   endfunction

   // Valid stays high after an item is taken; idling or draining lowers it.
   task automatic send_item(input logic act, input logic [IN_SAMPLE_W-1:0] sx,
                            input logic [IN_SAMPLE_W-1:0] sy, input logic [IN_SAMPLE_W-1:0] sz,
                            input logic last);
      while (!steady && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sz, sy, sx};
      req_tuser  <= act;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(act, $signed(sx), $signed(sy), $signed(sz), last);
      items_sent++;
      if (act == ACT_CLEAR) clears_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
   endtask

   function automatic logic [IN_SAMPLE_W-1:0] pick_sample(input sample_style_type style);
      case (style)
         STYLE_RAIL: begin
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         end
         STYLE_NEAR: begin
            return IN_SAMPLE_W'($urandom_range(400)) - IN_SAMPLE_W'(200);
         end
         default: begin
            return IN_SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   task automatic report(input string field, input longint expected, input longint actual);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
      fault_count++;
   endtask

   // result side: check each taken item, then choose the next ready level
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      bias_mean_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            fault_count++;
         end else begin
            want = pending_means.pop_front();
            means_checked++;
            if (rsp_tdata[BIAS_W-1:0] !== want.bias_x)
               report("bias_x", want.bias_x, $signed(rsp_tdata[BIAS_W-1:0]));
            if (rsp_tdata[2*BIAS_W-1:BIAS_W] !== want.bias_y)
               report("bias_y", want.bias_y, $signed(rsp_tdata[2*BIAS_W-1:BIAS_W]));
            if (rsp_tdata[3*BIAS_W-1:2*BIAS_W] !== want.bias_z)
               report("bias_z", want.bias_z, $signed(rsp_tdata[3*BIAS_W-1:2*BIAS_W]));
            if (rsp_tdata[3*BIAS_W+FILL_W-1:3*BIAS_W] !== want.fill)
               report("fill_count", want.fill, rsp_tdata[3*BIAS_W+FILL_W-1:3*BIAS_W]);
         end
      end
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 19);
      end
   end

   // extremes, truncation toward zero of both signs, push without batch end
   task automatic test_extremes();
      send_item(ACT_PUSH, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
      send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(ACT_PUSH, 16'hFFFF, 16'h0001, 16'h5555, 1'b0);
      send_item(ACT_PUSH, 16'h0001, 16'hFFFE, 16'hAAAA, 1'b0);
      send_item(ACT_PUSH, 16'h0001, 16'h0002, 16'h0000, 1'b1);
      send_item(ACT_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(ACT_PUSH, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
      send_item(ACT_PUSH, 16'h8000, 16'h7FFF, 16'h0001, 1'b1);
      wait_drained();
   endtask

   // clear ignores its sample fields and batch end, and yields nothing
   task automatic test_clear();
      send_item(ACT_PUSH, 16'h1234, 16'hEDCB, 16'h0F0F, 1'b0);
      send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(ACT_CLEAR, 16'hA5A5, 16'h5A5A, 16'h8001, 1'b1);
      send_item(ACT_PUSH, 16'h0100, 16'hFF00, 16'h0000, 1'b1);
      send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      wait_drained();
   endtask

   // fill the ring at the rails, then evict with the opposite rails on x and y
   task automatic test_full_window();
      steady = 1'b1;
      send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      for (int i = 1; i <= RING_DEPTH; i++)
         send_item(ACT_PUSH, 16'h7FFF, 16'h8000, 16'h7FFF, (i == 1) || (i % 128 == 0));
      steady = 1'b0;
      for (int i = 1; i <= 40; i++)
         send_item(ACT_PUSH, 16'h8000, 16'h7FFF, IN_SAMPLE_W'($urandom), (i % 8 == 0));
      wait_drained();
   endtask

   // hold the result side off while batch ends keep arriving
   task automatic test_backpressure();
      steady = 1'b1;
      hold_ticket++;
      for (int i = 0; i < 8; i++)
         send_item(ACT_PUSH, pick_sample(STYLE_FULL), pick_sample(STYLE_FULL),
                   pick_sample(STYLE_FULL), 1'b1);
      steady = 1'b0;
      wait_drained();
   endtask

   // batches of random content, with rare clears so the ring wraps often
   task automatic test_random();
      int unsigned      budget;
      int unsigned      burst;
      int unsigned      roll;
      sample_style_type style;
      budget = items_sent + RANDOM_ITEMS;
      while (items_sent < budget) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_item(ACT_CLEAR, IN_SAMPLE_W'($urandom), IN_SAMPLE_W'($urandom),
                      IN_SAMPLE_W'($urandom), 1'($urandom));
         end else if (roll < 10) begin
            send_item(ACT_PUSH, IN_SAMPLE_W'($urandom), IN_SAMPLE_W'($urandom),
                      IN_SAMPLE_W'($urandom), 1'($urandom));
         end else begin
            style = sample_style_type'($urandom_range(2));
            burst = $urandom_range(24, 1);
            for (int i = 1; i <= burst; i++)
               send_item(ACT_PUSH, pick_sample(style), pick_sample(style), pick_sample(style),
                         (i == burst) || ($urandom_range(7) == 0));
         end
         if ($urandom_range(49) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_clear();
      test_full_window();
      test_backpressure();
      steady = 1'b1;
      test_random();
      steady = 1'b0;
      test_random();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d clears), checked %0d means.", items_sent, clears_sent,
               means_checked);
      $display("Ring wrapped with %0d evictions; result side held off for %0d cycles once.",
               evictions, HOLD_CYCLES);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
